// File: design/rgb_gray_downscale_2x2_assert.svh
// Assertion macros used by the checker file.
`ifndef RGB_GRAY_DOWNSCALE_2X2_ASSERT_SVH
`define RGB_GRAY_DOWNSCALE_2X2_ASSERT_SVH

// Clocked assertion, ignored while reset is asserted.
`define RGBGD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RGBGD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/rgbgd_pkg.sv
`default_nettype none

package rgbgd_pkg;

    localparam int DEF_MAX_WIDTH = 64;

    localparam int WIDTH_W  = 7;
    localparam int HEIGHT_W = 12;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [WIDTH_W-1:0]  RESET_FRAME_WIDTH  = 7'd32;
    localparam logic [HEIGHT_W-1:0] RESET_FRAME_HEIGHT = 12'd32;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] gray_average;
        logic       frame_last;
    } t_result;

    // Position of one pixel in the frame; active marks the even part of the frame
    typedef struct packed {
        logic active;
        logic odd_col;
        logic odd_row;
        logic last;
    } t_pos;

    function automatic logic [7:0] gray_of(input t_pixel px);
        logic [8:0] sum;
        sum = {3'b0, px.red[7:2]} + {5'b0, px.red[7:4]} + {2'b0, px.green[7:1]}
            + {5'b0, px.green[7:4]} + {4'b0, px.blue[7:3]};
        return sum[7:0];
    endfunction

endpackage

`default_nettype wire

// File: design/rgbgd_pair_mem.sv
`default_nettype none

module rgbgd_pair_mem import rgbgd_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH / 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [8:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [8:0]    o_rdata
);

    logic [8:0] r_mem [DEPTH];
    logic [8:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/rgbgd_scan.sv
`default_nettype none

module rgbgd_scan import rgbgd_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int CW        = $clog2(DEF_MAX_WIDTH),
    parameter int PW        = $clog2(DEF_MAX_WIDTH / 2)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_advance,
    output t_pos                       o_pos,
    output logic      [PW-1:0]         o_ptr
);

    localparam int CMPW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

    logic [WIDTH_W-1:0]  r_frame_width;
    logic [HEIGHT_W-1:0] r_frame_height;
    logic [CW-1:0]       r_col, n_col;
    logic [HEIGHT_W-1:0] r_row, n_row;

    logic [WIDTH_W-1:0]  width_clamp;
    logic [WIDTH_W-1:0]  width_eff;
    logic [HEIGHT_W-1:0] height_eff;
    logic [WIDTH_W-1:0]  width_even;
    logic [HEIGHT_W-1:0] height_even;
    logic [CMPW-1:0]     col_ext;
    logic [CMPW-1:0]     col_inc;
    logic [HEIGHT_W:0]   row_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_FRAME_WIDTH;
            r_frame_height <= RESET_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        width_clamp = (CMPW'(r_frame_width) > CMPW'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
                                                                : r_frame_width;
        width_eff   = (width_clamp < WIDTH_W'(2)) ? WIDTH_W'(2) : width_clamp;
        height_eff  = (r_frame_height < HEIGHT_W'(2)) ? HEIGHT_W'(2) : r_frame_height;
        width_even  = {width_eff[WIDTH_W-1:1], 1'b0};
        height_even = {height_eff[HEIGHT_W-1:1], 1'b0};

        col_ext = CMPW'(r_col);
        col_inc = col_ext + CMPW'(1);
        row_inc = {1'b0, r_row} + (HEIGHT_W + 1)'(1);

        // wrap at the configured size, also when a new size leaves the count past it
        if (col_inc >= CMPW'(width_eff)) begin
            n_col = '0;
            n_row = (row_inc >= {1'b0, height_eff}) ? '0 : row_inc[HEIGHT_W-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.active  = (col_ext < CMPW'(width_even)) && (r_row < height_even);
    assign o_pos.odd_col = r_col[0];
    assign o_pos.odd_row = r_row[0];
    assign o_pos.last    = (col_ext == CMPW'(width_even) - CMPW'(1))
                        && (r_row == height_even - HEIGHT_W'(1));
    assign o_ptr         = PW'(r_col >> 1);

endmodule

`default_nettype wire

// File: design/rgb_gray_downscale_2x2.sv
// RGB to gray conversion with 2x2 box downscale.
// Input channel: i_valid / o_stall carry one RGB pixel per transaction, in raster
// order. Output channel: o_valid / i_stall carry one averaged gray value per 2x2
// block, given at the block's bottom-right pixel; frame_last marks the frame's
// final block. All other pixels produce nothing.
// Config: i_cfg_we writes frame_width (index 0) or frame_height (index 1) from
// i_cfg_data; write only while no pixel is in flight.
// Throughput: one pixel per clock while o_stall is low. A result-bearing pixel
// passes the input register, then the result register. The pair-sum line buffer
// is a MAX_WIDTH/2 entry memory with one write and one registered read port, read
// at the accept edge and written when an odd-column pixel of an even row leaves
// the input stage.
// Reset (synchronous, active low) restores both sizes to 32, clears the row and
// column counters, the left-pixel hold and both valid flags; the line buffer
// is not cleared and needs no clearing pass.
// When i_stall holds the result, the input stage keeps taking pixels that give
// no result; o_stall rises only when the input stage holds a result-bearing
// pixel behind a stalled result.
`default_nettype none

module rgb_gray_downscale_2x2 import rgbgd_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_pixel                i_pixel,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_result                    o_result
);

    localparam int CW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int PAIR_DEPTH = MAX_WIDTH / 2;
    localparam int PW         = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;

    logic          r_a_valid;
    t_pixel        r_a_pix;
    t_pos          r_a_pos;
    logic [PW-1:0] r_a_ptr;
    logic [7:0]    r_left;
    logic          r_o_valid;
    t_result       r_o_result;

    t_pos          scan_pos;
    logic [PW-1:0] scan_ptr;
    logic [8:0]    upper_pair;
    logic          accept;
    logic          a_emit;
    logic          a_advance;
    logic          out_free;
    logic          pair_we;
    logic [7:0]    gray;
    logic [8:0]    pair;
    logic [9:0]    block_sum;

    rgbgd_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW),
        .PW        (PW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_advance  (accept),
        .o_pos      (scan_pos),
        .o_ptr      (scan_ptr)
    );

    rgbgd_pair_mem #(
        .DEPTH (PAIR_DEPTH),
        .AW    (PW)
    ) u_pair_mem (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (r_a_ptr),
        .i_wdata (pair),
        .i_re    (accept),
        .i_raddr (scan_ptr),
        .o_rdata (upper_pair)
    );

    always_comb begin
        gray      = gray_of(r_a_pix);
        pair      = {1'b0, r_left} + {1'b0, gray};
        block_sum = {1'b0, upper_pair} + {1'b0, pair};

        a_emit    = r_a_pos.active && r_a_pos.odd_col && r_a_pos.odd_row;
        out_free  = !r_o_valid || !i_stall;
        a_advance = r_a_valid && (!a_emit || out_free);
        pair_we   = a_advance && r_a_pos.active && r_a_pos.odd_col && !r_a_pos.odd_row;
        o_stall   = r_a_valid && !a_advance;
        accept    = i_valid && !o_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (a_advance) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pix <= i_pixel;
            r_a_pos <= scan_pos;
            r_a_ptr <= scan_ptr;
        end
    end

    // hold the even-column gray value for the pair that follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (a_advance && r_a_pos.active && !r_a_pos.odd_col) begin
            r_left <= gray;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_advance && a_emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_advance && a_emit) begin
            r_o_result.gray_average <= block_sum[9:2];
            r_o_result.frame_last   <= r_a_pos.last;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_o_result;

endmodule

`default_nettype wire

// File: design/rgbgd_checker.sv
`default_nettype none
`include "rgb_gray_downscale_2x2_assert.svh"

module rgbgd_checker import rgbgd_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_cfg_we,
    input wire logic    o_stall,
    input wire logic    o_valid,
    input wire logic    i_stall,
    input wire t_result o_result
);

    // a stalled result stays offered and unchanged
    `RGBGD_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_valid && i_stall |=> o_valid && $stable(o_result), "result changed while stalled")

    // reset empties the result register
    `RGBGD_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !o_valid, "result valid right after reset")

    // the input side only backs up behind a stalled result
    `RGBGD_ASSERT(a_stall_cause, i_clk, i_rst_n,
        o_stall |-> o_valid && i_stall, "input stalled without output backpressure")

    // a config write must not land while the input stage is blocked
    `RGBGD_ASSERT(a_cfg_idle, i_clk, i_rst_n,
        i_cfg_we |-> !o_stall, "config written while input stage blocked")

endmodule

bind rgb_gray_downscale_2x2 rgbgd_checker u_rgbgd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_cfg_we   (i_cfg_we),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_result   (o_result)
);

`default_nettype wire
